[rtl/mrwt_pkg.sv]
// Package for the Miller-Rabin witness test: operand width, data types,
// controller states, verdict codes and the modular multiplier's control structs.
// No dependencies.
`timescale 1ns / 1ps

package mrwt_pkg;

  // operand width of candidate and witness
  localparam int WIDTH = 63;
  // one extra bit for sums and doubled values before reduction
  localparam int EXT_W = WIDTH + 1;
  // bit counter and power-of-two counter
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [EXT_W-1:0] ext_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    VERDICT_TRIVIAL   = 2'd0,
    VERDICT_TWO       = 2'd1,
    VERDICT_COMPOSITE = 2'd2,
    VERDICT_PASS      = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_SPLIT,
    S_PSTEP,
    S_PMUL_W,
    S_PSQR,
    S_PSQR_W,
    S_QSTEP,
    S_QSQR_W,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

[rtl/mrwt_if.sv]
// Handshake channels of the Miller-Rabin witness test: candidate/witness in,
// verdict out. Depends on mrwt_pkg.
`timescale 1ns / 1ps

interface mrwt_in_if;
  logic           valid;
  logic           ready;
  mrwt_pkg::word_t candidate;
  mrwt_pkg::word_t witness;

  modport source (output valid, output candidate, output witness, input ready);
  modport sink   (input valid, input candidate, input witness, output ready);
endinterface

interface mrwt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/mrwt_modmul.sv]
// Bit-serial modular multiplier: (p * q) mod m by shift-and-add, one bit of q
// per cycle, with conditional subtraction. Depends on mrwt_pkg.
`timescale 1ns / 1ps

module mrwt_modmul (
  input  logic               clk,
  input  logic               rst_n,
  input  mrwt_pkg::mm_ctrl_t ctrl,
  input  mrwt_pkg::word_t    op_p,
  input  mrwt_pkg::word_t    op_q,
  input  mrwt_pkg::word_t    modulus,
  output mrwt_pkg::mm_stat_t stat,
  output mrwt_pkg::word_t    product
);

  mrwt_pkg::word_t p_r, p_nxt;
  mrwt_pkg::word_t q_r, q_nxt;
  mrwt_pkg::word_t acc_r, acc_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  mrwt_pkg::ext_t  m_ext;
  mrwt_pkg::ext_t  sum_ext;
  mrwt_pkg::ext_t  dbl_ext;

  assign m_ext = {1'b0, modulus};

  // one shift-and-add step
  always_comb begin
    p_nxt    = p_r;
    q_nxt    = q_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sum_ext  = {1'b0, acc_r} + {1'b0, p_r};
    if (sum_ext >= m_ext) begin
      sum_ext = sum_ext - m_ext;
    end
    dbl_ext = {p_r, 1'b0};
    if (dbl_ext >= m_ext) begin
      dbl_ext = dbl_ext - m_ext;
    end
    if (ctrl.start) begin
      p_nxt    = op_p;
      q_nxt    = op_q;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (q_r == '0) begin
        // multiplier bits used up: drop busy, pulse done
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (q_r[0]) begin
          acc_nxt = sum_ext[mrwt_pkg::WIDTH-1:0];
        end
        p_nxt = dbl_ext[mrwt_pkg::WIDTH-1:0];
        q_nxt = q_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

`ifndef ASSERT_OFF
  // partial sum stays reduced while a product is under way
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (acc_r < modulus))
    else $error("modmul: accumulator not reduced");
  // doubled operand stays reduced while a product is under way
  a_p_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (p_r < modulus))
    else $error("modmul: shifted operand not reduced");
  // done follows a busy cycle and ends it
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("modmul: done without a finished product");
`endif

endmodule

[rtl/miller_rabin_witness_test.sv]
// Top level of the Miller-Rabin witness test: controller for reduction, split
// of n-1, square-and-multiply and the final squarings. Depends on mrwt_pkg,
// mrwt_if and mrwt_modmul.
//
//   channel  direction  payload                  handshake
//   in_ch    in         candidate, witness (63)  valid / ready
//   out_ch   out        verdict (2)              valid / ready
//
// One item at a time. Trivial candidates go straight to the output. Otherwise
// the witness is reduced modulo n bit by bit, twos are stripped from n-1, and
// each modular product runs in the bit-serial multiplier; at most 124 products
// (about 94 for a random full-width candidate) are needed.
// Synchronous active-low reset clears the controller and the output valid.
// The result sits in an output register, so a new item is taken while it waits.
`timescale 1ns / 1ps

module miller_rabin_witness_test (
  input logic        clk,
  input logic        rst_n,
  mrwt_in_if.sink    in_ch,
  mrwt_out_if.source out_ch
);

  mrwt_pkg::state_t   state_r, state_nxt;
  mrwt_pkg::word_t    n_r, n_nxt;
  mrwt_pkg::word_t    a_r, a_nxt;
  mrwt_pkg::word_t    e_r, e_nxt;
  mrwt_pkg::word_t    sq_r, sq_nxt;
  mrwt_pkg::word_t    res_r, res_nxt;
  mrwt_pkg::cnt_t     cnt_r, cnt_nxt;
  mrwt_pkg::cnt_t     t_r, t_nxt;
  mrwt_pkg::verdict_t verdict_r, verdict_nxt;
  logic               out_valid_r, out_valid_nxt;
  mrwt_pkg::verdict_t out_verdict_r, out_verdict_nxt;

  mrwt_pkg::mm_ctrl_t mm_ctrl;
  mrwt_pkg::mm_stat_t mm_stat;
  mrwt_pkg::word_t    mm_p;
  mrwt_pkg::word_t    mm_q;
  mrwt_pkg::word_t    mm_prod;

  mrwt_pkg::ext_t     rem_ext;
  mrwt_pkg::word_t    n_minus1;
  logic               slot_free;

  mrwt_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mm_ctrl),
    .op_p    (mm_p),
    .op_q    (mm_q),
    .modulus (n_r),
    .stat    (mm_stat),
    .product (mm_prod)
  );

  assign n_minus1  = n_r - mrwt_pkg::word_t'(1);
  assign slot_free = !out_valid_r || out_ch.ready;

  // next state and datapath control
  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    a_nxt           = a_r;
    e_nxt           = e_r;
    sq_nxt          = sq_r;
    res_nxt         = res_r;
    cnt_nxt         = cnt_r;
    t_nxt           = t_r;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;
    mm_ctrl.start   = 1'b0;
    mm_p            = res_r;
    mm_q            = sq_r;
    rem_ext         = {sq_r, a_r[mrwt_pkg::WIDTH-1]};
    if (rem_ext >= {1'b0, n_r}) begin
      rem_ext = rem_ext - {1'b0, n_r};
    end

    // drop the output item once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mrwt_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt   = in_ch.candidate;
          a_nxt   = in_ch.witness;
          e_nxt   = in_ch.candidate - mrwt_pkg::word_t'(1);
          sq_nxt  = '0;
          res_nxt = mrwt_pkg::word_t'(1);
          cnt_nxt = mrwt_pkg::cnt_t'(mrwt_pkg::WIDTH - 1);
          t_nxt   = '0;
          if (in_ch.candidate < mrwt_pkg::word_t'(2)) begin
            verdict_nxt = mrwt_pkg::VERDICT_TRIVIAL;
            state_nxt   = mrwt_pkg::S_EMIT;
          end else if (in_ch.candidate == mrwt_pkg::word_t'(2)) begin
            verdict_nxt = mrwt_pkg::VERDICT_TWO;
            state_nxt   = mrwt_pkg::S_EMIT;
          end else if (!in_ch.candidate[0]) begin
            verdict_nxt = mrwt_pkg::VERDICT_TRIVIAL;
            state_nxt   = mrwt_pkg::S_EMIT;
          end else begin
            state_nxt = mrwt_pkg::S_REDUCE;
          end
        end
      end
      mrwt_pkg::S_REDUCE: begin
        // shift in one witness bit, subtract n when the remainder reaches it
        sq_nxt = rem_ext[mrwt_pkg::WIDTH-1:0];
        a_nxt  = a_r << 1;
        cnt_nxt = cnt_r - mrwt_pkg::cnt_t'(1);
        if (cnt_r == '0) begin
          state_nxt = mrwt_pkg::S_SPLIT;
        end
      end
      mrwt_pkg::S_SPLIT: begin
        // strip one factor of two per cycle
        if (e_r[0]) begin
          state_nxt = mrwt_pkg::S_PSTEP;
        end else begin
          e_nxt = e_r >> 1;
          t_nxt = t_r + mrwt_pkg::cnt_t'(1);
        end
      end
      mrwt_pkg::S_PSTEP: begin
        if (e_r[0]) begin
          mm_ctrl.start = 1'b1;
          mm_p          = res_r;
          mm_q          = sq_r;
          state_nxt     = mrwt_pkg::S_PMUL_W;
        end else begin
          state_nxt = mrwt_pkg::S_PSQR;
        end
      end
      mrwt_pkg::S_PMUL_W: begin
        if (mm_stat.done) begin
          res_nxt   = mm_prod;
          state_nxt = mrwt_pkg::S_PSQR;
        end
      end
      mrwt_pkg::S_PSQR: begin
        // last exponent bit used: the power is done
        if (e_r[mrwt_pkg::WIDTH-1:1] == '0) begin
          state_nxt = mrwt_pkg::S_QSTEP;
        end else begin
          mm_ctrl.start = 1'b1;
          mm_p          = sq_r;
          mm_q          = sq_r;
          state_nxt     = mrwt_pkg::S_PSQR_W;
        end
      end
      mrwt_pkg::S_PSQR_W: begin
        if (mm_stat.done) begin
          sq_nxt    = mm_prod;
          e_nxt     = e_r >> 1;
          state_nxt = mrwt_pkg::S_PSTEP;
        end
      end
      mrwt_pkg::S_QSTEP: begin
        if (t_r == '0) begin
          verdict_nxt = (res_r != mrwt_pkg::word_t'(1)) ?
                        mrwt_pkg::VERDICT_COMPOSITE : mrwt_pkg::VERDICT_PASS;
          state_nxt   = mrwt_pkg::S_EMIT;
        end else begin
          mm_ctrl.start = 1'b1;
          mm_p          = res_r;
          mm_q          = res_r;
          state_nxt     = mrwt_pkg::S_QSQR_W;
        end
      end
      mrwt_pkg::S_QSQR_W: begin
        if (mm_stat.done) begin
          // square is one but the root was neither one nor n-1
          if (mm_prod == mrwt_pkg::word_t'(1) && res_r != mrwt_pkg::word_t'(1) &&
              res_r != n_minus1) begin
            verdict_nxt = mrwt_pkg::VERDICT_COMPOSITE;
            state_nxt   = mrwt_pkg::S_EMIT;
          end else begin
            res_nxt   = mm_prod;
            t_nxt     = t_r - mrwt_pkg::cnt_t'(1);
            state_nxt = mrwt_pkg::S_QSTEP;
          end
        end
      end
      mrwt_pkg::S_EMIT: begin
        // hold until the output register is free
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
          state_nxt       = mrwt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mrwt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrwt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    a_r           <= a_nxt;
    e_r           <= e_nxt;
    sq_r          <= sq_nxt;
    res_r         <= res_nxt;
    cnt_r         <= cnt_nxt;
    t_r           <= t_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  assign in_ch.ready    = (state_r == mrwt_pkg::S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = out_verdict_r;

`ifndef ASSERT_OFF
  // a finished product only arrives while the controller waits for one
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mm_stat.done |-> (state_r == mrwt_pkg::S_PMUL_W || state_r == mrwt_pkg::S_PSQR_W ||
                      state_r == mrwt_pkg::S_QSQR_W))
    else $error("top: product finished outside a wait state");
  // exponent never runs out before the power loop ends
  a_exp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrwt_pkg::S_PSTEP) |-> (e_r != '0))
    else $error("top: exponent empty in power loop");
  // powers stay reduced modulo the candidate
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrwt_pkg::S_PSTEP || state_r == mrwt_pkg::S_QSTEP) |->
      (sq_r < n_r && res_r < n_r))
    else $error("top: power register not reduced");
  // a product starts only when the multiplier is free
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    mm_ctrl.start |-> !mm_stat.busy)
    else $error("top: product started while multiplier busy");
`endif

endmodule
